// ===== rtl/jpd_pkg.sv =====
// jpd_pkg: shared types and constants for the joint packet deframer
// no dependencies; used by jpd_core, jpd_out_stage and joint_packet_deframer
`default_nettype none

package jpd_pkg;

    // protocol characters
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_Q = 8'h51;

    // packet type codes as reported
    localparam logic [1:0] KIND_S = 2'd0;
    localparam logic [1:0] KIND_C = 2'd1;
    localparam logic [1:0] KIND_R = 2'd2;
    localparam logic [1:0] KIND_A = 2'd3;

    // end status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CHECKSUM = 3'd1;
    localparam logic [2:0] ST_NO_FLOW  = 3'd2;
    localparam logic [2:0] ST_BAD_REQ  = 3'd3;
    localparam logic [2:0] ST_ILLEGAL  = 3'd4;

    // header flag bit positions
    localparam int FL_CHECKSUM = 0;
    localparam int FL_GRAN     = 1;
    localparam int FL_PTYPE    = 2;
    localparam int FL_CONT     = 4;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FLAGS   = 3'd1,
        PH_COUNT   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4,
        PH_REQ_E   = 3'd5,
        PH_REQ_Q   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       data_kind;
        logic       packet_end;
        logic [2:0] status;
        logic [1:0] packet_type;
        logic [4:0] header_flags;
        logic [7:0] entry_count;
        logic [9:0] packet_length;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/jpd_core.sv =====
// jpd_core: deframing state machine, one received word per accepted cycle
// depends on jpd_pkg for phase type, codes and result struct
`default_nettype none

module jpd_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_data,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_rx_byte,
    output jpd_pkg::t_result     o_result,
    output logic                 o_emit
);

    // payload words of a packet with the given header
    function automatic logic [9:0] payload_total(input logic [1:0] typ,
                                                 input logic [4:0] flg,
                                                 input logic [7:0] cnt);
        logic [1:0] mult;
        begin
            if (typ == jpd_pkg::KIND_A) begin
                mult = 2'd1;
            end else begin
                mult = 2'(1 + 32'(flg[jpd_pkg::FL_PTYPE]) + 32'(flg[jpd_pkg::FL_GRAN]));
            end
            payload_total = 10'(cnt) * 10'(mult);
        end
    endfunction

    function automatic logic [9:0] packet_total(input logic [1:0] typ,
                                                input logic [4:0] flg,
                                                input logic [7:0] cnt);
        logic [9:0] hdr;
        begin
            hdr = (typ == jpd_pkg::KIND_C) ? 10'd1 : 10'd3;
            packet_total = hdr + payload_total(typ, flg, cnt)
                         + 10'(flg[jpd_pkg::FL_CHECKSUM]);
        end
    endfunction

    jpd_pkg::t_phase r_phase, n_phase;
    logic [1:0] r_type, n_type;
    logic [4:0] r_flags, n_flags;
    logic [7:0] r_count, n_count;
    logic [9:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic       r_flow_ck, n_flow_ck;
    logic       r_flow_wide, n_flow_wide;
    logic [7:0] r_flow_cnt, n_flow_cnt;
    logic       r_cont_ok;

    logic       finish;
    logic       emit;
    logic       dv, kind, pend;
    logic [7:0] dbyte;
    logic [2:0] st;
    logic [9:0] len;
    logic [9:0] tot_cur, dlen_cur, pos_inc, tot_new;

    assign tot_cur  = payload_total(r_type, r_flags, r_count);
    assign dlen_cur = 10'(r_count) * 10'(2'(1 + 32'(r_flags[jpd_pkg::FL_PTYPE])));
    assign pos_inc  = r_pos + 10'd1;

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_flags     = r_flags;
        n_count     = r_count;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_flow_ck   = r_flow_ck;
        n_flow_wide = r_flow_wide;
        n_flow_cnt  = r_flow_cnt;
        finish      = 1'b0;
        emit        = 1'b0;
        dv          = 1'b0;
        kind        = 1'b0;
        pend        = 1'b0;
        dbyte       = 8'd0;
        st          = jpd_pkg::ST_OK;
        len         = 10'd0;
        tot_new     = 10'd0;

        case (r_phase)
            jpd_pkg::PH_FLAGS: begin
                n_sum   = r_sum + i_rx_byte;
                n_flags = i_rx_byte[4:0];
                n_phase = jpd_pkg::PH_COUNT;
            end
            jpd_pkg::PH_COUNT: begin
                n_sum   = r_sum + i_rx_byte;
                n_count = i_rx_byte;
                tot_new = payload_total(n_type, n_flags, n_count);
                if (tot_new != 10'd0) begin
                    n_pos   = 10'd0;
                    n_phase = jpd_pkg::PH_PAYLOAD;
                end else if (n_flags[jpd_pkg::FL_CHECKSUM]) begin
                    n_phase = jpd_pkg::PH_CHECK;
                end else begin
                    emit   = 1'b1;
                    pend   = 1'b1;
                    len    = packet_total(n_type, n_flags, n_count);
                    finish = 1'b1;
                end
            end
            jpd_pkg::PH_PAYLOAD: begin
                n_sum = r_sum + i_rx_byte;
                kind  = (r_type == jpd_pkg::KIND_A)
                     || (r_type == jpd_pkg::KIND_S && r_pos >= dlen_cur);
                n_pos = pos_inc;
                emit  = 1'b1;
                dv    = 1'b1;
                dbyte = i_rx_byte;
                if (pos_inc >= tot_cur) begin
                    if (r_flags[jpd_pkg::FL_CHECKSUM]) begin
                        n_phase = jpd_pkg::PH_CHECK;
                    end else begin
                        pend   = 1'b1;
                        len    = packet_total(r_type, r_flags, r_count);
                        finish = 1'b1;
                    end
                end
            end
            jpd_pkg::PH_CHECK: begin
                emit = 1'b1;
                pend = 1'b1;
                if (i_rx_byte != r_sum) begin
                    st      = jpd_pkg::ST_CHECKSUM;
                    n_phase = jpd_pkg::PH_IDLE;
                end else begin
                    len    = packet_total(r_type, r_flags, r_count);
                    finish = 1'b1;
                end
            end
            jpd_pkg::PH_REQ_E: begin
                n_sum = r_sum + i_rx_byte;
                if (i_rx_byte != jpd_pkg::CH_E) begin
                    emit    = 1'b1;
                    pend    = 1'b1;
                    st      = jpd_pkg::ST_BAD_REQ;
                    n_phase = jpd_pkg::PH_IDLE;
                end else begin
                    n_phase = jpd_pkg::PH_REQ_Q;
                end
            end
            jpd_pkg::PH_REQ_Q: begin
                n_sum   = r_sum + i_rx_byte;
                n_phase = jpd_pkg::PH_IDLE;
                emit    = 1'b1;
                pend    = 1'b1;
                if (i_rx_byte != jpd_pkg::CH_Q) begin
                    st = jpd_pkg::ST_BAD_REQ;
                end else begin
                    len = 10'd3;
                end
            end
            default: begin
                // type word
                n_phase = jpd_pkg::PH_IDLE;
                n_sum   = i_rx_byte;
                n_pos   = 10'd0;
                n_flags = 5'd0;
                n_count = 8'd0;
                if (i_rx_byte == jpd_pkg::CH_S || i_rx_byte == jpd_pkg::CH_A) begin
                    n_type  = (i_rx_byte == jpd_pkg::CH_S) ? jpd_pkg::KIND_S
                                                           : jpd_pkg::KIND_A;
                    n_phase = jpd_pkg::PH_FLAGS;
                end else if (i_rx_byte == jpd_pkg::CH_R) begin
                    n_type  = jpd_pkg::KIND_R;
                    n_phase = jpd_pkg::PH_REQ_E;
                end else if (i_rx_byte == jpd_pkg::CH_C) begin
                    n_type = jpd_pkg::KIND_C;
                    if (!r_cont_ok) begin
                        emit = 1'b1;
                        pend = 1'b1;
                        st   = jpd_pkg::ST_NO_FLOW;
                    end else begin
                        n_flags = {2'b00, r_flow_wide, 1'b0, r_flow_ck};
                        n_count = r_flow_cnt;
                        tot_new = payload_total(n_type, n_flags, n_count);
                        if (tot_new != 10'd0) begin
                            n_phase = jpd_pkg::PH_PAYLOAD;
                        end else if (n_flags[jpd_pkg::FL_CHECKSUM]) begin
                            n_phase = jpd_pkg::PH_CHECK;
                        end else begin
                            emit   = 1'b1;
                            pend   = 1'b1;
                            len    = packet_total(n_type, n_flags, n_count);
                            finish = 1'b1;
                        end
                    end
                end else begin
                    n_type = 2'd0;
                    emit   = 1'b1;
                    pend   = 1'b1;
                    st     = jpd_pkg::ST_ILLEGAL;
                end
            end
        endcase

        // good end: save the agreed flow where the header asks for it
        if (finish) begin
            n_phase = jpd_pkg::PH_IDLE;
            if (n_flags[jpd_pkg::FL_CONT] && (n_type == jpd_pkg::KIND_S
                    || (n_type == jpd_pkg::KIND_A && !n_flags[jpd_pkg::FL_GRAN]))) begin
                n_flow_ck   = n_flags[jpd_pkg::FL_CHECKSUM];
                n_flow_wide = n_flags[jpd_pkg::FL_PTYPE];
                n_flow_cnt  = n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jpd_pkg::PH_IDLE;
            r_type      <= 2'd0;
            r_flags     <= 5'd0;
            r_count     <= 8'd0;
            r_pos       <= 10'd0;
            r_sum       <= 8'd0;
            r_flow_ck   <= 1'b0;
            r_flow_wide <= 1'b0;
            r_flow_cnt  <= 8'd0;
            r_cont_ok   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cont_ok <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase     <= n_phase;
                r_type      <= n_type;
                r_flags     <= n_flags;
                r_count     <= n_count;
                r_pos       <= n_pos;
                r_sum       <= n_sum;
                r_flow_ck   <= n_flow_ck;
                r_flow_wide <= n_flow_wide;
                r_flow_cnt  <= n_flow_cnt;
            end
        end
    end

    always_comb begin
        o_result.data_byte     = dbyte;
        o_result.data_valid    = dv;
        o_result.data_kind     = kind;
        o_result.packet_end    = pend;
        o_result.status        = st;
        o_result.packet_type   = n_type;
        o_result.header_flags  = n_flags;
        o_result.entry_count   = n_count;
        o_result.packet_length = len;
    end

    assign o_emit = emit;

endmodule

`default_nettype wire

// ===== rtl/jpd_out_stage.sv =====
// jpd_out_stage: result register between the deframer and the downstream side
// depends on jpd_pkg for the result struct
`default_nettype none

module jpd_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  jpd_pkg::t_result      i_result,
    input  wire logic             i_stall,
    output logic                  o_full_stall,
    output logic                  o_valid,
    output jpd_pkg::t_result      o_result
);

    logic             r_valid;
    jpd_pkg::t_result r_result;

    // room when empty or when the held word leaves this cycle
    assign o_full_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/joint_packet_deframer.sv =====
// joint_packet_deframer: top level of the joint-control link packet deframer
// depends on jpd_pkg, jpd_core and jpd_out_stage
//
//  channel   dir  handshake                     payload
//  rx        in   i_rx_valid / o_rx_stall       i_rx_byte
//  result    out  o_res_valid / i_res_stall     o_data_* , o_packet_*, o_status,
//                                               o_header_flags, o_entry_count
//  config    in   i_cfg_we (no stall)           i_cfg_data
//
// one received word per clock while o_rx_stall is low; the step logic sits between the state
// registers and the result register, so a result shows in the cycle after its word
// header words that end nothing leave no result
// i_rst_n is synchronous: phase goes idle, flow and config clear
// o_rx_stall rises only while the result register is full and downstream stalls
`default_nettype none

module joint_packet_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    // received words
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    // results
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic [7:0]      o_data_byte,
    output logic            o_data_valid,
    output logic            o_data_kind,
    output logic            o_packet_end,
    output logic [2:0]      o_status,
    output logic [1:0]      o_packet_type,
    output logic [4:0]      o_header_flags,
    output logic [7:0]      o_entry_count,
    output logic [9:0]      o_packet_length
);

    logic             rx_accept;
    logic             core_emit;
    logic             full_stall;
    jpd_pkg::t_result core_result;
    jpd_pkg::t_result out_result;

    // a word is taken whenever the result register has room
    assign o_rx_stall = full_stall;
    assign rx_accept  = i_rx_valid && !full_stall;

    jpd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (rx_accept),
        .i_rx_byte  (i_rx_byte),
        .o_result   (core_result),
        .o_emit     (core_emit)
    );

    jpd_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (rx_accept && core_emit),
        .i_result     (core_result),
        .i_stall      (i_res_stall),
        .o_full_stall (full_stall),
        .o_valid      (o_res_valid),
        .o_result     (out_result)
    );

    // unpack the held result onto the field ports
    assign o_data_byte     = out_result.data_byte;
    assign o_data_valid    = out_result.data_valid;
    assign o_data_kind     = out_result.data_kind;
    assign o_packet_end    = out_result.packet_end;
    assign o_status        = out_result.status;
    assign o_packet_type   = out_result.packet_type;
    assign o_header_flags  = out_result.header_flags;
    assign o_entry_count   = out_result.entry_count;
    assign o_packet_length = out_result.packet_length;

    // a result that does not end a packet always carries a payload word
    a_mid_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_packet_end) |-> o_data_valid)
        else $error("result without end and without payload word");

    // failed packets report no length
    a_err_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != jpd_pkg::ST_OK) |-> (o_packet_length == 10'd0))
        else $error("length reported on failed packet");

    // a good request packet is always three words
    a_req_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_packet_end && o_status == jpd_pkg::ST_OK
         && o_packet_type == jpd_pkg::KIND_R) |-> (o_packet_length == 10'd3))
        else $error("request length wrong");

    // upstream is held off only by a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> (o_res_valid && i_res_stall))
        else $error("rx stalled without a pending result");

    // non-payload results carry zero data fields
    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_data_valid) |-> (o_data_byte == 8'd0 && !o_data_kind))
        else $error("data fields set without payload word");

endmodule

`default_nettype wire
